[hdl/ahash_pkg.sv]
// Shared types, constants and helpers for the average hash generator.
// No dependencies; the controller, datapath and top level import this package.
package ahash_pkg;

  // Fixed widths of the port fields
  localparam int SAMPLE_W = 16;
  localparam int HASH_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // Register map (index of register in the address space)
  localparam logic REG_SAMPLE_COUNT = 1'b0;

  // Reset value of the sample count register
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  // Controller states
  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_READ  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // store the sample beat and add it to the sum
    logic rd_issue;  // read the next stored sample for the compare pass
    logic clear;     // restart the frame: zero count, sum and read index
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_sample;  // the sample now loaded completes the frame
    logic byte_end;     // the read now issued is the eighth of a byte
    logic pipe_idle;    // no read or product in flight
    logic last_byte;    // every stored sample has been read
  } status_t;

  // Round down to a multiple of eight, then bound to [8, top]
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] raw,
                                                     input logic [COUNT_W-1:0] top);
    logic [COUNT_W-1:0] c;
    c = {raw[COUNT_W-1:3], 3'b000};
    if (c < COUNT_W'(8)) c = COUNT_W'(8);
    if (c > top) c = top;
    return c;
  endfunction

endpackage

[hdl/ahash_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ahash_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/ahash_ctrl.sv]
// Controller state machine: sequences frame load, compare pass and byte output.
// Depends on ahash_pkg.
module ahash_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  output logic              hash_valid,
  input  logic              hash_stall,
  input  logic              cfg_wr,
  input  ahash_pkg::status_t status,
  output ahash_pkg::cmd_t    cmd
);
  import ahash_pkg::*;

  state_t state;
  state_t state_next;

  // Handshake outputs follow the state
  assign sample_stall = (state != S_LOAD);
  assign hash_valid   = (state == S_EMIT);

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.clear    = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (sample_valid) begin
          cmd.load = 1'b1;
          if (status.last_sample) state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        if (status.byte_end) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (status.pipe_idle) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!hash_stall) begin
          if (status.last_byte) begin
            cmd.clear  = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_READ;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
    // A register write restarts the frame
    if (cfg_wr) begin
      cmd.load     = 1'b0;
      cmd.rd_issue = 1'b0;
      cmd.clear    = 1'b1;
      state_next   = S_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

endmodule

[hdl/ahash_dp.sv]
// Datapath: sample store, running sum, scaled compare and byte packing.
// Depends on ahash_pkg and ahash_ram.
module ahash_dp #(
  parameter int MAX_SAMPLES = ahash_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = ahash_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ahash_pkg::SAMPLE_W-1:0]  sample,
  input  logic [ahash_pkg::COUNT_W-1:0]   count_reg,
  input  ahash_pkg::cmd_t                 cmd,
  output ahash_pkg::status_t              status,
  output logic [ahash_pkg::HASH_W-1:0]    hash_byte,
  output logic                            last_byte
);
  import ahash_pkg::*;

  // Usable sample bits and the longest frame the count register can select
  localparam int SB      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int TOP8    = (MAX_SAMPLES / 8) * 8;
  localparam int CNT_CAP = (1 << COUNT_W) - 8;
  localparam int FL_MAX  = (TOP8 < CNT_CAP) ? TOP8 : CNT_CAP;
  localparam int IDX_W   = $clog2(FL_MAX);
  localparam int CNT_W   = $clog2(FL_MAX + 1);
  localparam int SUM_W   = SB + CNT_W;
  localparam int PROD_W  = SB + COUNT_W;
  localparam logic [COUNT_W-1:0] FL_TOP = COUNT_W'(FL_MAX);

  logic [COUNT_W-1:0] frame_len;
  logic [CNT_W-1:0]   seen;
  logic [CNT_W-1:0]   rd_idx;
  logic [SUM_W-1:0]   sum;
  logic [SB-1:0]      rd_data;
  logic               rd_v;
  logic [PROD_W-1:0]  prod;
  logic               prod_v;

  assign frame_len = clamp_count(count_reg, FL_TOP);

  // Sample store
  ahash_ram #(.WIDTH(SB), .DEPTH(FL_MAX)) u_store (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (seen[IDX_W-1:0]),
    .wr_data (sample[SB-1:0]),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Frame fill count, running sum and read index
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      seen   <= '0;
      sum    <= '0;
      rd_idx <= '0;
    end else begin
      if (cmd.load) begin
        seen <= seen + CNT_W'(1);
        sum  <= sum + SUM_W'(sample[SB-1:0]);
      end
      if (cmd.rd_issue) rd_idx <= rd_idx + CNT_W'(1);
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v   <= cmd.rd_issue;
      prod_v <= rd_v;
    end
  end

  // Scale the sample by the frame length
  always_ff @(posedge clk) begin
    if (rd_v) prod <= PROD_W'(rd_data) * PROD_W'(frame_len);
  end

  // Compare against the sum and shift the bit in from the top
  always_ff @(posedge clk) begin
    if (prod_v) hash_byte <= {(prod >= PROD_W'(sum)), hash_byte[HASH_W-1:1]};
  end

  assign last_byte = (COUNT_W'(rd_idx) == frame_len);

  // Status to the controller
  always_comb begin
    status.last_sample = ((COUNT_W'(seen) + COUNT_W'(1)) == frame_len);
    status.byte_end    = (rd_idx[2:0] == 3'b111);
    status.pipe_idle   = !rd_v && !prod_v;
    status.last_byte   = last_byte;
  end

endmodule

[hdl/average_hash_generator_top.sv]
// Top level of the average hash generator: register port, controller, datapath.
// Depends on ahash_pkg, ahash_ctrl, ahash_dp (and ahash_ram below it).
//
// Usage: send one frame of sample_count samples as beats on the sample
// channel (sample_valid / sample_stall). After the last sample the block
// compares every stored sample against the frame mean (sample*count >= sum)
// and sends count/8 beats on the hash channel (hash_valid / hash_stall),
// bit k of byte b for sample 8*b+k, last_byte set on the final beat.
// Samples load at one per cycle while sample_stall is low. Each hash byte is
// then built from eight reads of the single-read sample store, a drain of
// the multiply/compare pipeline (read data, product and byte registers)
// and one output beat.
// sample_stall stays high from the last sample until the last byte is taken.
// A stalled hash beat holds byte and flag; the pass waits for it.
// Reset (rst, synchronous) empties the frame and sets sample_count to 64.
// Writing sample_count (APB, any address with paddr[2] low) drops any partial frame.
module average_hash_generator_top #(
  parameter int MAX_SAMPLES = ahash_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = ahash_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ahash_pkg::APB_AW-1:0]   paddr,
  input  logic [ahash_pkg::APB_DW-1:0]   pwdata,
  output logic [ahash_pkg::APB_DW-1:0]   prdata,
  output logic                           pready,
  input  logic [ahash_pkg::SAMPLE_W-1:0] sample,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  output logic [ahash_pkg::HASH_W-1:0]   hash_byte,
  output logic                           last_byte,
  output logic                           hash_valid,
  input  logic                           hash_stall
);
  import ahash_pkg::*;

  logic [COUNT_W-1:0] count_reg;
  logic               cfg_wr;
  cmd_t               cmd;
  status_t            status;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SAMPLE_COUNT);

  always_ff @(posedge clk) begin
    if (rst)         count_reg <= COUNT_RESET;
    else if (cfg_wr) count_reg <= pwdata[COUNT_W-1:0];
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_SAMPLE_COUNT: prdata = APB_DW'(count_reg);
      default:          prdata = '0;
    endcase
  end

  ahash_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .hash_valid   (hash_valid),
    .hash_stall   (hash_stall),
    .cfg_wr       (cfg_wr),
    .status       (status),
    .cmd          (cmd)
  );

  ahash_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .count_reg (count_reg),
    .cmd       (cmd),
    .status    (status),
    .hash_byte (hash_byte),
    .last_byte (last_byte)
  );

endmodule
